FILE: sv/itsf_pkg.sv
// ----------------------------------------------------------------------------
// itsf_pkg
// shared types and codes for the ice tuple selection unit
// ----------------------------------------------------------------------------
package itsf_pkg;

  // default depth of the tuple table
  localparam int unsigned MaxTuplesDefault = 8;

  // one stored tuple: remote ip, remote port, protocol, local port
  localparam int unsigned TupleW = 65;

  typedef enum logic [1:0] {
    OpBind   = 2'd0,
    OpRemove = 2'd1,
    OpForce  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    IceNew          = 2'd0,
    IceConnected    = 2'd1,
    IceCompleted    = 2'd2,
    IceDisconnected = 2'd3
  } ice_state_e;

  typedef enum logic [1:0] {
    EvNone         = 2'd0,
    EvConnected    = 2'd1,
    EvCompleted    = 2'd2,
    EvDisconnected = 2'd3
  } ice_event_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the input beat, clear scan results
    logic scan;    // read one table entry
    logic commit;  // apply the operation, register the result
  } itsf_cmd_t;

endpackage

FILE: sv/itsf_ctrl.sv
// ----------------------------------------------------------------------------
// itsf_ctrl
// sequencer: accept, table scan, drain, commit, result strobe
// ----------------------------------------------------------------------------
module itsf_ctrl import itsf_pkg::*; #(
  parameter int unsigned MAX_TUPLES = MaxTuplesDefault
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              start_i,
  output logic                                              busy_o,
  output logic                                              done_o,
  output itsf_cmd_t                                         cmd_o,
  output logic [((MAX_TUPLES > 1) ? $clog2(MAX_TUPLES) : 1)-1:0] rd_addr_o
);

  localparam int unsigned IdxW = (MAX_TUPLES > 1) ? $clog2(MAX_TUPLES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_TUPLES - 1);

  typedef enum logic [1:0] {
    IdleSt,
    ScanSt,
    DrainSt,
    CommitSt
  } ctrl_state_e;

  ctrl_state_e     state_q;
  logic [IdxW-1:0] cnt_q;
  logic            done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IdleSt;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        IdleSt: begin
          if (start_i) begin
            state_q <= ScanSt;
            cnt_q   <= '0;
          end
        end
        ScanSt: begin
          if (cnt_q == LastIdx) begin
            state_q <= DrainSt;
          end else begin
            cnt_q <= cnt_q + IdxW'(1);
          end
        end
        DrainSt: begin
          state_q <= CommitSt;
        end
        CommitSt: begin
          state_q <= IdleSt;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= IdleSt;
        end
      endcase
    end
  end

  assign busy_o        = (state_q != IdleSt);
  assign done_o        = done_q;
  assign rd_addr_o     = cnt_q;
  assign cmd_o.load    = start_i && (state_q == IdleSt);
  assign cmd_o.scan    = (state_q == ScanSt);
  assign cmd_o.commit  = (state_q == CommitSt);

endmodule

FILE: sv/itsf_dpath.sv
// ----------------------------------------------------------------------------
// itsf_dpath
// tuple table, age ranks, selection and link state, result registers
// ----------------------------------------------------------------------------
module itsf_dpath import itsf_pkg::*; #(
  parameter int unsigned MAX_TUPLES = MaxTuplesDefault
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  itsf_cmd_t                                         cmd_i,
  input  logic [((MAX_TUPLES > 1) ? $clog2(MAX_TUPLES) : 1)-1:0] rd_addr_i,
  input  logic [1:0]                                        op_i,
  input  logic                                              use_candidate_i,
  input  logic                                              protocol_i,
  input  logic [15:0]                                       local_port_i,
  input  logic [31:0]                                       peer_addr_i,
  input  logic [15:0]                                       peer_port_i,
  output logic [1:0]                                        ice_state_o,
  output logic [1:0]                                        state_event_o,
  output logic                                              selected_valid_o,
  output logic [2:0]                                        selected_slot_o,
  output logic                                              selection_changed_o,
  output logic                                              tuple_known_o,
  output logic                                              table_full_o
);

  localparam int unsigned IdxW = (MAX_TUPLES > 1) ? $clog2(MAX_TUPLES) : 1;

  // tuple store, entries only match where the used bit is set
  logic [TupleW-1:0] mem_q [MAX_TUPLES];
  logic [TupleW-1:0] rd_data_q;
  logic [IdxW-1:0]   cmp_idx_q;
  logic              cmp_vld_q;

  // captured input beat
  logic [1:0]        op_q;
  logic              uc_q;
  logic [TupleW-1:0] key_q;

  // scan results
  logic              found_q, free_v_q, r0_v_q, r1_v_q;
  logic [IdxW-1:0]   found_idx_q, found_rank_q, free_idx_q, r0_idx_q, r1_idx_q;

  // session state
  ice_state_e        link_q, link_d;
  logic              sel_pres_q, sel_pres_d;
  logic [IdxW-1:0]   sel_idx_q, sel_idx_d;
  logic              used_q [MAX_TUPLES];
  logic              used_d [MAX_TUPLES];
  logic [IdxW-1:0]   rank_q [MAX_TUPLES];
  logic [IdxW-1:0]   rank_d [MAX_TUPLES];

  // result registers
  logic [1:0]        ice_state_q, state_event_q;
  logic              sel_valid_q, changed_q, known_q, full_q;
  logic [2:0]        sel_slot_q;

  logic              do_add, do_rem, do_sel, lose, full, changed, best_v;
  logic [IdxW-1:0]   sel_tgt, best_idx;
  ice_event_e        event_d;
  logic [IdxW+2:0]   sel_ext;
  logic              hit;

  // ---------------- scan ----------------

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
    cmp_idx_q <= rd_addr_i;
    if (cmd_i.commit && do_add) begin
      mem_q[free_idx_q] <= key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan;
    end
  end

  assign hit = used_q[cmp_idx_q] && (rd_data_q == key_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_i;
      uc_q     <= use_candidate_i;
      key_q    <= {peer_addr_i, peer_port_i, protocol_i, local_port_i};
      found_q  <= 1'b0;
      free_v_q <= 1'b0;
      r0_v_q   <= 1'b0;
      r1_v_q   <= 1'b0;
    end else if (cmp_vld_q) begin
      if (hit && !found_q) begin
        found_q      <= 1'b1;
        found_idx_q  <= cmp_idx_q;
        found_rank_q <= rank_q[cmp_idx_q];
      end
      // lowest free slot
      if (!used_q[cmp_idx_q] && !free_v_q) begin
        free_v_q   <= 1'b1;
        free_idx_q <= cmp_idx_q;
      end
      // newest and second newest tuples
      if (used_q[cmp_idx_q] && (rank_q[cmp_idx_q] == '0)) begin
        r0_v_q   <= 1'b1;
        r0_idx_q <= cmp_idx_q;
      end
      if (used_q[cmp_idx_q] && (rank_q[cmp_idx_q] == IdxW'(1))) begin
        r1_v_q   <= 1'b1;
        r1_idx_q <= cmp_idx_q;
      end
    end
  end

  // ---------------- commit ----------------

  // after removing the selected tuple the newest remaining one takes over
  assign best_v   = (found_rank_q == '0) ? r1_v_q : r0_v_q;
  assign best_idx = (found_rank_q == '0) ? r1_idx_q : r0_idx_q;

  always_comb begin
    link_d     = link_q;
    sel_pres_d = sel_pres_q;
    sel_idx_d  = sel_idx_q;
    event_d    = EvNone;
    do_add     = 1'b0;
    do_rem     = 1'b0;
    do_sel     = 1'b0;
    lose       = 1'b0;
    full       = 1'b0;
    changed    = 1'b0;
    sel_tgt    = found_idx_q;

    case (op_q)
      OpBind: begin
        if (!found_q) begin
          if (free_v_q) begin
            do_add  = 1'b1;
            sel_tgt = free_idx_q;
          end else begin
            full = 1'b1;
          end
        end
        if (link_q == IceNew || link_q == IceDisconnected) begin
          if (!full) begin
            do_sel  = 1'b1;
            link_d  = uc_q ? IceCompleted : IceConnected;
            event_d = uc_q ? EvCompleted : EvConnected;
          end
        end else if (uc_q && !full) begin
          do_sel = 1'b1;
          if (link_q == IceConnected) begin
            link_d  = IceCompleted;
            event_d = EvCompleted;
          end
        end
      end
      OpRemove: begin
        if (found_q) begin
          do_rem = 1'b1;
          if (sel_pres_q && (sel_idx_q == found_idx_q)) begin
            if (best_v) begin
              do_sel  = 1'b1;
              sel_tgt = best_idx;
            end else begin
              lose = 1'b1;
            end
          end
        end
      end
      OpForce: begin
        do_sel = found_q;
      end
      default: begin
      end
    endcase

    if (do_sel) begin
      changed    = !sel_pres_q || (sel_idx_q != sel_tgt);
      sel_pres_d = 1'b1;
      sel_idx_d  = sel_tgt;
    end
    if (lose) begin
      changed    = 1'b1;
      sel_pres_d = 1'b0;
      sel_idx_d  = '0;
      link_d     = IceDisconnected;
      event_d    = EvDisconnected;
    end

    // ranks stay dense: new tuple is rank zero, removal closes the gap
    for (int i = 0; i < MAX_TUPLES; i++) begin
      used_d[i] = used_q[i];
      rank_d[i] = rank_q[i];
      if (do_add) begin
        if (used_q[i]) begin
          rank_d[i] = rank_q[i] + IdxW'(1);
        end
        if (IdxW'(i) == free_idx_q) begin
          used_d[i] = 1'b1;
          rank_d[i] = '0;
        end
      end
      if (do_rem) begin
        if (IdxW'(i) == found_idx_q) begin
          used_d[i] = 1'b0;
        end else if (used_q[i] && (rank_q[i] > found_rank_q)) begin
          rank_d[i] = rank_q[i] - IdxW'(1);
        end
      end
    end
  end

  assign sel_ext = {3'b000, sel_idx_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q     <= IceNew;
      sel_pres_q <= 1'b0;
      sel_idx_q  <= '0;
      for (int i = 0; i < MAX_TUPLES; i++) begin
        used_q[i] <= 1'b0;
      end
    end else if (cmd_i.commit) begin
      link_q     <= link_d;
      sel_pres_q <= sel_pres_d;
      sel_idx_q  <= sel_idx_d;
      for (int i = 0; i < MAX_TUPLES; i++) begin
        used_q[i] <= used_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      for (int i = 0; i < MAX_TUPLES; i++) begin
        rank_q[i] <= rank_d[i];
      end
      ice_state_q   <= link_d;
      state_event_q <= event_d;
      sel_valid_q   <= sel_pres_d;
      sel_slot_q    <= sel_pres_d ? sel_ext[2:0] : 3'b000;
      changed_q     <= changed;
      known_q       <= found_q;
      full_q        <= full;
    end
  end

  assign ice_state_o         = ice_state_q;
  assign state_event_o       = state_event_q;
  assign selected_valid_o    = sel_valid_q;
  assign selected_slot_o     = sel_slot_q;
  assign selection_changed_o = changed_q;
  assign tuple_known_o       = known_q;
  assign table_full_o        = full_q;

endmodule

FILE: sv/ice_tuple_selection_fsm_unit.sv
// ----------------------------------------------------------------------------
// ice_tuple_selection_fsm_unit
// ice-lite link state and transport tuple selection for one session
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             payload
// -------   ---------  --------------------  ----------------------------------
// request   in         start & !busy         op, use_candidate, protocol,
//                                            local_port, peer_addr, peer_port
// result    out        done_o (one cycle)    ice_state, state_event,
//                                            selected_valid, selected_slot,
//                                            selection_changed, tuple_known,
//                                            table_full
//
// each request beat takes MAX_TUPLES + 2 cycles of busy: the tuple table is a
// single-port memory that is scanned one slot per cycle (MAX_TUPLES cycles),
// one cycle drains the registered read, one cycle commits
// the result beat shows on done_o in the cycle after commit, when busy is
// already low, so a new request may be taken in that same cycle
// the receiver cannot stall: every result beat is taken as it appears
// reset is asynchronous, active low: state new, empty table, no selection
//
module ice_tuple_selection_fsm_unit import itsf_pkg::*; #(
  parameter int unsigned MAX_TUPLES = MaxTuplesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic        use_candidate_i,
  input  logic        protocol_i,
  input  logic [15:0] local_port_i,
  input  logic [31:0] peer_addr_i,
  input  logic [15:0] peer_port_i,
  output logic        done_o,
  output logic [1:0]  ice_state_o,
  output logic [1:0]  state_event_o,
  output logic        selected_valid_o,
  output logic [2:0]  selected_slot_o,
  output logic        selection_changed_o,
  output logic        tuple_known_o,
  output logic        table_full_o
);

  localparam int unsigned IdxW = (MAX_TUPLES > 1) ? $clog2(MAX_TUPLES) : 1;

  itsf_cmd_t       cmd;
  logic [IdxW-1:0] rd_addr;

  // sequencer: owns the scan counter and the result strobe
  itsf_ctrl #(
    .MAX_TUPLES (MAX_TUPLES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_o    (busy),
    .done_o    (done_o),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr)
  );

  // table, ranks, selection, link state and result registers
  itsf_dpath #(
    .MAX_TUPLES (MAX_TUPLES)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .rd_addr_i           (rd_addr),
    .op_i                (op_i),
    .use_candidate_i     (use_candidate_i),
    .protocol_i          (protocol_i),
    .local_port_i        (local_port_i),
    .peer_addr_i         (peer_addr_i),
    .peer_port_i         (peer_port_i),
    .ice_state_o         (ice_state_o),
    .state_event_o       (state_event_o),
    .selected_valid_o    (selected_valid_o),
    .selected_slot_o     (selected_slot_o),
    .selection_changed_o (selection_changed_o),
    .tuple_known_o       (tuple_known_o),
    .table_full_o        (table_full_o)
  );

`ifndef SYNTH
  // a result beat always closes a request that was in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result beat without a request in flight");

  // an accepted request keeps the unit busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("request accepted but unit not busy");

  // a dropped tuple leaves selection and state untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && table_full_o) |->
      (!tuple_known_o && !selection_changed_o && (state_event_o == EvNone)))
    else $error("dropped tuple changed the session");

  // no selection reads as slot zero, and losing it means disconnected
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !selected_valid_o) |->
      ((selected_slot_o == 3'b000) &&
       (!selection_changed_o || (ice_state_o == IceDisconnected))))
    else $error("inconsistent empty selection");
`endif

endmodule

FILE: bench/ice_tuple_selection_fsm_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ice_tuple_selection_fsm_unit_tb
// self-checking bench for the ice tuple selection unit
// a directed opening walks the link through every state and table corner,
// then about 1300 random binding, remove and force beats follow, drawn
// mostly from a small tuple pool so that hits, a full table and a lost
// selection are frequent; every result beat is checked against a local
// model of the tuple table, ranks, selection and link state
// ----------------------------------------------------------------------------
module ice_tuple_selection_fsm_unit_tb import itsf_pkg::*;;

  localparam int unsigned TableDepth  = MaxTuplesDefault;
  localparam int unsigned RandomItems = 1300;
  localparam int unsigned PoolSize    = 12;
  localparam int unsigned CycleLimit  = 400000;

  // op code the block leaves unassigned, must change nothing
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic        proto;
    logic [15:0] lport;
    logic [31:0] rip;
    logic [15:0] rport;
  } tuple_t;

  typedef struct packed {
    ice_state_e  state;
    ice_event_e  ev;
    logic        sel_valid;
    logic [2:0]  sel_slot;
    logic        changed;
    logic        known;
    logic        full;
  } ice_result_t;

  // --------------------------------------------------------------------------
  // link model and result scoreboard
  // --------------------------------------------------------------------------
  class tuple_scoreboard;
    ice_state_e   link_state;
    bit           slot_used   [TableDepth];
    bit [47:0]    slot_remote [TableDepth];
    bit [16:0]    slot_local  [TableDepth];
    int unsigned  slot_rank   [TableDepth];
    bit           sel_present;
    int           sel_index;
    ice_result_t  expected_q[$];
    int unsigned  errors;
    int unsigned  checked;

    function new();
      link_state = IceNew;
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_rank[i] = 0;
      end
      sel_present = 1'b0;
      sel_index   = 0;
      errors      = 0;
      checked     = 0;
    endfunction

    function int find_tuple(bit [47:0] remote, bit [16:0] lockey);
      for (int i = 0; i < TableDepth; i++)
        if (slot_used[i] && slot_remote[i] == remote && slot_local[i] == lockey)
          return i;
      return -1;
    endfunction

    // lowest free slot, stored as the newest; the others age by one
    function int store_tuple(bit [47:0] remote, bit [16:0] lockey);
      int free_slot;
      free_slot = -1;
      for (int i = 0; i < TableDepth; i++)
        if (!slot_used[i] && free_slot < 0) free_slot = i;
      if (free_slot < 0) return -1;
      for (int i = 0; i < TableDepth; i++)
        if (slot_used[i]) slot_rank[i]++;
      slot_used[free_slot]   = 1'b1;
      slot_remote[free_slot] = remote;
      slot_local[free_slot]  = lockey;
      slot_rank[free_slot]   = 0;
      return free_slot;
    endfunction

    // returns whether the selection moved
    function bit pick(int idx);
      bit moved;
      moved       = !sel_present || sel_index != idx;
      sel_present = 1'b1;
      sel_index   = idx;
      return moved;
    endfunction

    function void note_request(logic [1:0] op, logic uc, tuple_t t);
      bit [47:0]   remote;
      bit [16:0]   lockey;
      int          hit;
      int          idx;
      int          best;
      int unsigned drop_rank;
      ice_result_t res;
      remote = {t.rip, t.rport};
      lockey = {t.proto, t.lport};
      hit    = find_tuple(remote, lockey);
      res    = '0;
      if (op == OpBind) begin
        if (link_state == IceNew || link_state == IceDisconnected) begin
          idx = (hit >= 0) ? hit : store_tuple(remote, lockey);
          if (idx < 0) begin
            res.full = 1'b1;
          end else begin
            res.changed = pick(idx);
            link_state  = uc ? IceCompleted : IceConnected;
            res.ev      = uc ? EvCompleted : EvConnected;
          end
        end else begin
          idx = hit;
          if (idx < 0) begin
            idx = store_tuple(remote, lockey);
            if (idx < 0) res.full = 1'b1;
          end
          if (idx >= 0 && uc) begin
            res.changed = pick(idx);
            if (link_state == IceConnected) begin
              link_state = IceCompleted;
              res.ev     = EvCompleted;
            end
          end
        end
      end else if (op == OpRemove) begin
        if (hit >= 0) begin
          drop_rank      = slot_rank[hit];
          slot_used[hit] = 1'b0;
          for (int i = 0; i < TableDepth; i++)
            if (slot_used[i] && slot_rank[i] > drop_rank) slot_rank[i]--;
          if (sel_present && sel_index == hit) begin
            best = -1;
            for (int i = 0; i < TableDepth; i++)
              if (slot_used[i] && (best < 0 || slot_rank[i] < slot_rank[best])) best = i;
            if (best >= 0) begin
              res.changed = pick(best);
            end else begin
              sel_present = 1'b0;
              sel_index   = 0;
              res.changed = 1'b1;
              link_state  = IceDisconnected;
              res.ev      = EvDisconnected;
            end
          end
        end
      end else if (op == OpForce) begin
        if (hit >= 0) res.changed = pick(hit);
      end
      res.state     = link_state;
      res.sel_valid = sel_present;
      res.sel_slot  = sel_present ? 3'(sel_index) : 3'd0;
      res.known     = (hit >= 0);
      expected_q.push_back(res);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void report_mismatch(string what);
      $display("[%0t] result %0d: %s", $time, checked, what);
      errors++;
    endfunction

    function void compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
    endfunction

    function void check_result(ice_result_t got);
      ice_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with no request outstanding");
        return;
      end
      want = expected_q.pop_front();
      compare_field("ice_state", got.state, want.state);
      compare_field("state_event", got.ev, want.ev);
      compare_field("selected_valid", got.sel_valid, want.sel_valid);
      compare_field("selected_slot", got.sel_slot, want.sel_slot);
      compare_field("selection_changed", got.changed, want.changed);
      compare_field("tuple_known", got.known, want.known);
      compare_field("table_full", got.full, want.full);
      checked++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and block under test
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  op_i;
  logic        use_candidate_i;
  logic        protocol_i;
  logic [15:0] local_port_i;
  logic [31:0] peer_addr_i;
  logic [15:0] peer_port_i;
  logic        done_o;
  logic [1:0]  ice_state_o;
  logic [1:0]  state_event_o;
  logic        selected_valid_o;
  logic [2:0]  selected_slot_o;
  logic        selection_changed_o;
  logic        tuple_known_o;
  logic        table_full_o;

  tuple_scoreboard sb;
  ice_result_t     observed;
  int unsigned     cycle_count;

  ice_tuple_selection_fsm_unit #(
    .MAX_TUPLES (TableDepth)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .op_i                (op_i),
    .use_candidate_i     (use_candidate_i),
    .protocol_i          (protocol_i),
    .local_port_i        (local_port_i),
    .peer_addr_i         (peer_addr_i),
    .peer_port_i         (peer_port_i),
    .done_o              (done_o),
    .ice_state_o         (ice_state_o),
    .state_event_o       (state_event_o),
    .selected_valid_o    (selected_valid_o),
    .selected_slot_o     (selected_slot_o),
    .selection_changed_o (selection_changed_o),
    .tuple_known_o       (tuple_known_o),
    .table_full_o        (table_full_o)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit, far above the slowest correct run
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result monitor: a result beat lives for exactly one cycle, no back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      observed.state     = ice_state_e'(ice_state_o);
      observed.ev        = ice_event_e'(state_event_o);
      observed.sel_valid = selected_valid_o;
      observed.sel_slot  = selected_slot_o;
      observed.changed   = selection_changed_o;
      observed.known     = tuple_known_o;
      observed.full      = table_full_o;
      sb.check_result(observed);
    end
  end

  // --------------------------------------------------------------------------
  // request driver, called and returning at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_request(logic [1:0] op, logic uc, tuple_t t);
    start           <= 1'b1;
    op_i            <= op;
    use_candidate_i <= uc;
    protocol_i      <= t.proto;
    local_port_i    <= t.lport;
    peer_addr_i     <= t.rip;
    peer_port_i     <= t.rport;
    // beat is taken at the first rising edge with busy low
    do @(posedge clk_i); while (busy);
    sb.note_request(op, uc, t);
    @(negedge clk_i);
  endtask

  // sender gap; the payload wanders meanwhile, the block must ignore it
  task automatic idle_for(int unsigned cycles);
    repeat (cycles) begin
      start           <= 1'b0;
      op_i            <= 2'($urandom);
      use_candidate_i <= 1'($urandom);
      protocol_i      <= 1'($urandom);
      local_port_i    <= 16'($urandom);
      peer_addr_i     <= $urandom;
      peer_port_i     <= 16'($urandom);
      @(negedge clk_i);
    end
  endtask

  // hold off until every outstanding result beat has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  function automatic tuple_t fresh_tuple();
    return {1'($urandom), 16'($urandom), 32'($urandom), 16'($urandom)};
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    tuple_t      dir_tuples [9];
    tuple_t      pool [PoolSize];
    tuple_t      t;
    logic [1:0]  op_code;
    int unsigned roll;
    int unsigned burst_left;
    bit          draining;

    sb              = new();
    rst_ni          = 1'b0;
    start           = 1'b0;
    op_i            = '0;
    use_candidate_i = 1'b0;
    protocol_i      = 1'b0;
    local_port_i    = '0;
    peer_addr_i     = '0;
    peer_port_i     = '0;

    // directed tuples: all-zero, all-one, then plain distinct ones
    dir_tuples[0] = '0;
    dir_tuples[1] = '1;
    for (int i = 2; i < 9; i++)
      dir_tuples[i] = {i[0], 16'h1000 + 16'(i), 32'hc0a8_0000 + 32'(i), 16'd3478};

    // random pool; the last four differ from the first four in one field only
    for (int i = 0; i < 8; i++) pool[i] = fresh_tuple();
    pool[8]        = pool[0];
    pool[8].proto  = ~pool[0].proto;
    pool[9]        = pool[1];
    pool[9].lport  = pool[1].lport ^ (16'd1 << $urandom_range(15));
    pool[10]       = pool[2];
    pool[10].rip   = pool[2].rip ^ (32'd1 << $urandom_range(31));
    pool[11]       = pool[3];
    pool[11].rport = pool[3].rport ^ (16'd1 << $urandom_range(15));

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, back to back
    send_request(OpBind, 1'b0, dir_tuples[0]);   // new -> connected, selects it
    send_request(OpBind, 1'b0, dir_tuples[1]);   // connected, stored only
    send_request(OpBind, 1'b1, dir_tuples[1]);   // use-candidate -> completed
    send_request(OpBind, 1'b0, dir_tuples[2]);   // completed, stored, no event
    send_request(OpBind, 1'b1, dir_tuples[2]);   // completed, selection moves
    for (int i = 3; i < 8; i++)
      send_request(OpBind, 1'b0, dir_tuples[i]); // fill the table
    send_request(OpBind, 1'b1, dir_tuples[8]);   // table full, dropped
    send_request(OpForce, 1'b0, dir_tuples[0]);  // force a stored tuple
    send_request(OpForce, 1'b0, dir_tuples[8]);  // force unknown, flag only
    send_request(OpRemove, 1'b0, dir_tuples[3]); // remove unselected
    send_request(OpRemove, 1'b0, dir_tuples[0]); // remove selected, newest wins
    send_request(OpRemove, 1'b0, dir_tuples[8]); // remove unknown
    send_request(OpUnused, 1'b1, dir_tuples[1]); // unused op
    send_request(OpRemove, 1'b0, dir_tuples[1]);
    send_request(OpRemove, 1'b0, dir_tuples[2]);
    for (int i = 4; i < 8; i++)
      send_request(OpRemove, 1'b0, dir_tuples[i]); // last one leaves -> disconnected
    send_request(OpBind, 1'b1, dir_tuples[0]);   // disconnected -> completed
    wait_drained();

    // random part: fill and drain phases alternate so the table swings
    // between empty and full
    burst_left = 1;
    for (int n = 0; n < RandomItems; n++) begin
      draining = ((n / 64) % 2) == 1;
      roll     = $urandom_range(99);
      if (!draining)
        op_code = (roll < 60) ? OpBind : (roll < 75) ? OpRemove :
                  (roll < 93) ? OpForce : OpUnused;
      else
        op_code = (roll < 20) ? OpBind : (roll < 80) ? OpRemove :
                  (roll < 95) ? OpForce : OpUnused;
      t = ($urandom_range(9) == 0) ? fresh_tuple() : pool[$urandom_range(PoolSize - 1)];
      send_request(op_code, $urandom_range(99) < 40, t);

      if (n % 256 == 255) begin
        wait_drained();
      end else begin
        burst_left--;
        if (burst_left == 0) begin
          idle_for($urandom_range(1, 15));
          // mostly short bursts, now and then a long unbroken stretch
          burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 12);
        end
      end
    end

    // let every result land, then watch for strays over a few beat times
    wait_drained();
    repeat (2 * TableDepth + 8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
